// File: src/tccw_pkg.sv
// Shared types and constants for the text console cell writer.
// Depends on nothing; the controller, datapath and top level refer to it by scoped names.
package tccw_pkg;

    localparam int DEF_ROWS    = 25;
    localparam int DEF_COLUMNS = 80;

    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int BLANK_W = 7;
    localparam int CELL_W  = CHAR_W + ATTR_W;
    localparam int KIND_W  = 3;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h00;

    typedef enum logic [KIND_W-1:0] {
        KIND_SHOW       = 3'd0,
        KIND_SHOW_ATTR  = 3'd1,
        KIND_CLEAR      = 3'd2,
        KIND_SET_CURSOR = 3'd3,
        KIND_READ_CELL  = 3'd4
    } t_kind;

    typedef struct packed {
        logic latch;
        logic sweep_clr;
        logic sweep_step;
        logic wr_reset;
        logic wr_blank;
        logic wr_show;
        logic copy_rd;
        logic rd_target;
        logic cur_advance;
        logic cur_set;
        logic cur_home;
        logic cur_bottom;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_last;
        logic copy_last;
        logic at_last_cell;
    } t_dp_stat;

endpackage

// File: src/tccw_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/tccw_ctrl.sv
// Controller state machine: sequences each request and the memory sweeps.
// Depends on tccw_pkg; drives the datapath through t_dp_cmd.
module tccw_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [tccw_pkg::KIND_W-1:0]        i_kind,
    input  tccw_pkg::t_dp_stat                 i_stat,
    output tccw_pkg::t_dp_cmd                  o_cmd,
    output logic                               o_busy,
    output logic                               o_done
);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SHOW,
        ST_COPY,
        ST_DRAIN,
        ST_BLANK,
        ST_CLEAR,
        ST_SET,
        ST_NOP,
        ST_READ,
        ST_READ_DATA
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;
    tccw_pkg::t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            ST_INIT: begin
                cmd.wr_reset   = 1'b1;
                cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    cmd.sweep_clr = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    cmd.latch = 1'b1;
                    unique case (i_kind)
                        tccw_pkg::KIND_SHOW,
                        tccw_pkg::KIND_SHOW_ATTR:  n_state = ST_SHOW;
                        tccw_pkg::KIND_CLEAR: begin
                            cmd.sweep_clr = 1'b1;
                            n_state       = ST_CLEAR;
                        end
                        tccw_pkg::KIND_SET_CURSOR: n_state = ST_SET;
                        tccw_pkg::KIND_READ_CELL:  n_state = ST_READ;
                        default:                   n_state = ST_NOP;
                    endcase
                end
            end
            ST_SHOW: begin
                cmd.wr_show     = 1'b1;
                cmd.cur_advance = 1'b1;
                if (i_stat.at_last_cell) begin
                    cmd.sweep_clr = 1'b1;
                    n_state       = ST_COPY;
                end else begin
                    cmd.finish = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_COPY: begin
                cmd.copy_rd    = 1'b1;
                cmd.sweep_step = 1'b1;
                if (i_stat.copy_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_BLANK;
            end
            ST_BLANK: begin
                cmd.wr_blank   = 1'b1;
                cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    cmd.cur_bottom = 1'b1;
                    cmd.finish     = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                cmd.wr_blank   = 1'b1;
                cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    cmd.cur_home = 1'b1;
                    cmd.finish   = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_SET: begin
                cmd.cur_set = 1'b1;
                cmd.finish  = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_NOP: begin
                cmd.finish = 1'b1;
                n_state    = ST_IDLE;
            end
            ST_READ: begin
                cmd.rd_target = 1'b1;
                n_state       = ST_READ_DATA;
            end
            ST_READ_DATA: begin
                cmd.finish = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= cmd.finish;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;

endmodule

// File: src/tccw_dp.sv
// Datapath: cell memory, cursor, attributes, sweep counter and result registers.
// Depends on tccw_pkg and tccw_ram; obeys t_dp_cmd from the controller.
module tccw_dp #(
    parameter int ROWS    = tccw_pkg::DEF_ROWS,
    parameter int COLUMNS = tccw_pkg::DEF_COLUMNS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tccw_pkg::t_dp_cmd             i_cmd,
    output tccw_pkg::t_dp_stat            o_stat,
    input  logic [tccw_pkg::KIND_W-1:0]   i_kind,
    input  logic [tccw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tccw_pkg::ATTR_W-1:0]   i_attribute,
    input  logic [tccw_pkg::ROW_W-1:0]    i_target_row,
    input  logic [tccw_pkg::COL_W-1:0]    i_target_column,
    input  logic                          i_cfg_wr,
    input  logic [tccw_pkg::BLANK_W-1:0]  i_cfg_data,
    output logic [tccw_pkg::CHAR_W-1:0]   o_cell_char,
    output logic [tccw_pkg::ATTR_W-1:0]   o_cell_attribute,
    output logic [tccw_pkg::ROW_W-1:0]    o_cursor_row,
    output logic [tccw_pkg::COL_W-1:0]    o_cursor_column,
    output logic                          o_status
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    logic [tccw_pkg::KIND_W-1:0]  r_kind;
    logic [tccw_pkg::CHAR_W-1:0]  r_char;
    logic [tccw_pkg::ATTR_W-1:0]  r_attr_in;
    logic [tccw_pkg::ROW_W-1:0]   r_tgt_row;
    logic [tccw_pkg::COL_W-1:0]   r_tgt_col;
    logic [tccw_pkg::BLANK_W-1:0] r_blank;
    logic [tccw_pkg::ATTR_W-1:0]  r_cur_attr;
    logic [tccw_pkg::ATTR_W-1:0]  n_cur_attr;
    logic [tccw_pkg::ROW_W-1:0]   r_cur_row;
    logic [tccw_pkg::ROW_W-1:0]   n_cur_row;
    logic [tccw_pkg::COL_W-1:0]   r_cur_col;
    logic [tccw_pkg::COL_W-1:0]   n_cur_col;
    logic [AW-1:0]                r_cur_addr;
    logic [AW-1:0]                n_cur_addr;
    logic [AW-1:0]                r_sweep;
    logic                         r_copy_pend;
    logic [AW-1:0]                r_copy_addr;
    logic [tccw_pkg::CHAR_W-1:0]  r_cell_char;
    logic [tccw_pkg::ATTR_W-1:0]  r_cell_attr;
    logic [tccw_pkg::ROW_W-1:0]   r_out_row;
    logic [tccw_pkg::COL_W-1:0]   r_out_col;
    logic                         r_status;

    logic                         in_range;
    logic                         at_last;
    logic [AW-1:0]                tgt_addr;
    logic [tccw_pkg::ATTR_W-1:0]  show_attr;
    logic [tccw_pkg::ATTR_W-1:0]  blank_attr;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [tccw_pkg::CELL_W-1:0]  wr_data;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [tccw_pkg::CELL_W-1:0]  rd_data;
    logic                         is_read;
    logic                         is_set;

    assign in_range = ({1'b0, r_tgt_row} < (tccw_pkg::ROW_W + 1)'(ROWS))
                   && ({1'b0, r_tgt_col} < (tccw_pkg::COL_W + 1)'(COLUMNS));
    assign tgt_addr = AW'(r_tgt_row) * AW'(COLUMNS) + AW'(r_tgt_col);
    assign at_last  = (r_cur_addr == AW'(CELLS - 1));
    assign is_read  = (r_kind == tccw_pkg::KIND_READ_CELL);
    assign is_set   = (r_kind == tccw_pkg::KIND_SET_CURSOR);

    assign show_attr  = (r_kind == tccw_pkg::KIND_SHOW_ATTR) ? r_attr_in : r_cur_attr;
    assign blank_attr = {1'b0, r_blank};

    assign o_stat.sweep_last   = (r_sweep == AW'(CELLS - 1));
    assign o_stat.copy_last    = (r_sweep == AW'(CELLS - COLUMNS - 1));
    assign o_stat.at_last_cell = at_last;

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_sweep;
        wr_data = {tccw_pkg::RESET_ATTR, tccw_pkg::BLANK_CHAR};
        priority if (r_copy_pend) begin
            wr_addr = r_copy_addr;
            wr_data = rd_data;
        end else if (i_cmd.wr_show) begin
            wr_addr = r_cur_addr;
            wr_data = {show_attr, r_char};
        end else if (i_cmd.wr_blank) begin
            wr_data = {blank_attr, tccw_pkg::BLANK_CHAR};
        end else if (i_cmd.wr_reset) begin
            wr_data = {tccw_pkg::RESET_ATTR, tccw_pkg::BLANK_CHAR};
        end else begin
            wr_en = 1'b0;
        end
    end

    assign rd_en   = i_cmd.copy_rd | i_cmd.rd_target;
    assign rd_addr = i_cmd.copy_rd ? AW'(r_sweep + AW'(COLUMNS)) : tgt_addr;

    tccw_ram #(
        .WIDTH (tccw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_cur_row  = r_cur_row;
        n_cur_col  = r_cur_col;
        n_cur_addr = r_cur_addr;
        n_cur_attr = r_cur_attr;
        if (i_cmd.wr_show) begin
            n_cur_attr = show_attr;
        end
        priority if (i_cmd.cur_home) begin
            n_cur_row  = '0;
            n_cur_col  = '0;
            n_cur_addr = '0;
            n_cur_attr = blank_attr;
        end else if (i_cmd.cur_bottom) begin
            n_cur_row  = tccw_pkg::ROW_W'(ROWS - 1);
            n_cur_col  = '0;
            n_cur_addr = AW'(CELLS - COLUMNS);
        end else if (i_cmd.cur_set && in_range) begin
            n_cur_row  = r_tgt_row;
            n_cur_col  = r_tgt_col;
            n_cur_addr = tgt_addr;
        end else if (i_cmd.cur_advance && !at_last) begin
            n_cur_addr = r_cur_addr + AW'(1);
            if (r_cur_col == tccw_pkg::COL_W'(COLUMNS - 1)) begin
                n_cur_col = '0;
                n_cur_row = r_cur_row + tccw_pkg::ROW_W'(1);
            end else begin
                n_cur_col = r_cur_col + tccw_pkg::COL_W'(1);
            end
        end else begin
            n_cur_row = r_cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank     <= tccw_pkg::BLANK_W'(tccw_pkg::RESET_ATTR);
            r_cur_attr  <= tccw_pkg::RESET_ATTR;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_cur_addr  <= '0;
            r_sweep     <= '0;
            r_copy_pend <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_blank <= i_cfg_data;
            end
            r_cur_attr  <= n_cur_attr;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_cur_addr  <= n_cur_addr;
            r_copy_pend <= i_cmd.copy_rd;
            if (i_cmd.sweep_clr) begin
                r_sweep <= '0;
            end else if (i_cmd.sweep_step) begin
                r_sweep <= r_sweep + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_copy_addr <= r_sweep;
        if (i_cmd.latch) begin
            r_kind    <= i_kind;
            r_char    <= i_char_code;
            r_attr_in <= i_attribute;
            r_tgt_row <= i_target_row;
            r_tgt_col <= i_target_column;
        end
        if (i_cmd.finish) begin
            r_cell_char <= (is_read && in_range) ? rd_data[tccw_pkg::CHAR_W-1:0] : '0;
            r_cell_attr <= (is_read && in_range) ? rd_data[tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W]
                                                 : '0;
            r_status    <= (is_read || is_set) && !in_range;
            r_out_row   <= n_cur_row;
            r_out_col   <= n_cur_col;
        end
    end

    assign o_cell_char      = r_cell_char;
    assign o_cell_attribute = r_cell_attr;
    assign o_cursor_row     = r_out_row;
    assign o_cursor_column  = r_out_col;
    assign o_status         = r_status;

endmodule

// File: src/text_console_cell_writer.sv
// Top level of the text console cell writer: controller plus datapath.
// Depends on tccw_pkg, tccw_ctrl, tccw_dp and, through the datapath, tccw_ram.
//
// Channel   Direction  Handshake                      Payload
// command   in         start high while busy low      i_kind, i_char_code, i_attribute,
//                                                     i_target_row, i_target_column
// result    out        o_done strobe, one cycle       o_cell_char, o_cell_attribute,
//                                                     o_cursor_row, o_cursor_column, o_status
// config    in         i_cfg_valid and o_cfg_ready    i_cfg_data (blank attribute)
//
// Show at the last cell adds a scroll through the single write port of the cell memory,
// one cell per cycle. After reset a clearing pass fills the memory while busy is high.
// The result appears in the cycle after the request finishes and cannot be held off.
// The configuration port is always ready.
module text_console_cell_writer #(
    parameter int ROWS    = tccw_pkg::DEF_ROWS,
    parameter int COLUMNS = tccw_pkg::DEF_COLUMNS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tccw_pkg::KIND_W-1:0]   i_kind,
    input  logic [tccw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tccw_pkg::ATTR_W-1:0]   i_attribute,
    input  logic [tccw_pkg::ROW_W-1:0]    i_target_row,
    input  logic [tccw_pkg::COL_W-1:0]    i_target_column,
    output logic                          o_done,
    output logic [tccw_pkg::CHAR_W-1:0]   o_cell_char,
    output logic [tccw_pkg::ATTR_W-1:0]   o_cell_attribute,
    output logic [tccw_pkg::ROW_W-1:0]    o_cursor_row,
    output logic [tccw_pkg::COL_W-1:0]    o_cursor_column,
    output logic                          o_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tccw_pkg::BLANK_W-1:0]  i_cfg_data
);

    tccw_pkg::t_dp_cmd  cmd;
    tccw_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    tccw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    tccw_dp #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_kind           (i_kind),
        .i_char_code      (i_char_code),
        .i_attribute      (i_attribute),
        .i_target_row     (i_target_row),
        .i_target_column  (i_target_column),
        .i_cfg_wr         (i_cfg_valid & o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_cell_char      (o_cell_char),
        .o_cell_attribute (o_cell_attribute),
        .o_cursor_row     (o_cursor_row),
        .o_cursor_column  (o_cursor_column),
        .o_status         (o_status)
    );

`ifndef SYNTHESIS
    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_finish_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> busy)
        else $error("request finished while idle");

    a_one_writer : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.wr_show, cmd.wr_blank, cmd.wr_reset}))
        else $error("more than one write source selected");

    a_cursor_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ({1'b0, o_cursor_row} < (tccw_pkg::ROW_W + 1)'(ROWS)))
        else $error("reported cursor row off the screen");
`endif

endmodule
